@@ sv/avcb64_pkg.sv @@
`timescale 1ns / 1ps
package avcb64_pkg;

   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] CharComma = 8'h2c;
   localparam logic [7:0] CharPad   = 8'h3d;

   // one accepted byte gives at most four characters
   typedef struct packed {
      logic [3:0][7:0] chars;    // chars[0] goes out first
      logic [2:0]      count;    // 1..4
      logic            char_ok;  // 0 only for a bare end marker
      logic            last;     // final character of the group ends the record
   } grp_type;

   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] ch;
      if (v < 6'd26) begin
         ch = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         ch = 8'h61 + {2'b00, v} - 8'd26;
      end else if (v < 6'd62) begin
         ch = 8'h30 + {2'b00, v} - 8'd52;
      end else if (v == 6'd62) begin
         ch = 8'h2b;
      end else begin
         ch = 8'h2f;
      end
      return ch;
   endfunction

endpackage

@@ sv/avc_config_to_base64_param_sets_core.sv @@
`timescale 1ns / 1ps
// Path: a request's group is written into the group queue, then loaded into the back
// end's group register, from which its first character shows on the rsp_ ports. Throughput:
// one character per cycle while popped with groups queued; a request is taken every cycle
// while the group queue has room, so bytes that each close a group of four are taken only
// as fast as their characters drain. The rate is set by the single-character result port.
// Reset (synchronous, active high) returns the parser to idle and empties queue and output.
module avc_config_to_base64_param_sets_core #(
   parameter int QUEUE_DEPTH = avcb64_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_first,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_last
);
   import avcb64_pkg::*;

   // front to queue
   logic    q_full;
   logic    q_push;
   grp_type q_push_grp;

   // queue to back
   logic    q_valid;
   logic    q_pop;
   grp_type q_pop_grp;

   // Front: parse the record one byte per request, build the group of characters
   // that byte causes (comma, Base64 digits, padding or a bare end marker).
   avcb64_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_byte (req_data_byte),
      .req_first     (req_first),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_grp         (q_push_grp)
   );

   // Short queue of groups: lets the parser run ahead while characters drain.
   avcb64_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_grp (q_push_grp),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_grp  (q_pop_grp)
   );

   // Back: hold one group, advance one character per pop, load the next group
   // in the same cycle the last character goes.
   avcb64_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_grp          (q_pop_grp),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_char   (rsp_out_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last)
   );

endmodule

@@ sv/avcb64_front.sv @@
`timescale 1ns / 1ps
module avcb64_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  logic [7:0]          req_data_byte,
   input  logic                req_first,
   input  logic                q_full,
   output logic                q_push,
   output avcb64_pkg::grp_type q_grp
);
   import avcb64_pkg::*;

   localparam logic [2:0] PhIdle     = 3'd0;
   localparam logic [2:0] PhHeader   = 3'd1;
   localparam logic [2:0] PhSpsCount = 3'd2;
   localparam logic [2:0] PhLenHi    = 3'd3;
   localparam logic [2:0] PhLenLo    = 3'd4;
   localparam logic [2:0] PhData     = 3'd5;
   localparam logic [2:0] PhPpsCount = 3'd6;
   localparam logic [2:0] PhDone     = 3'd7;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  hdr_ff, hdr_in;
   logic [7:0]  sets_ff, sets_in;
   logic        pps_ff, pps_in;
   logic        sps_done_ff, sps_done_in;
   logic [7:0]  lenhi_ff, lenhi_in;
   logic [15:0] left_ff, left_in;
   logic [15:0] pend_ff, pend_in;
   logic [1:0]  pcnt_ff, pcnt_in;

   logic        accept;
   logic        ended;
   logic [2:0]  n;
   grp_type     grp;
   logic [7:0]  b;
   logic [7:0]  b0;
   logic [7:0]  b1;
   logic [7:0]  sets_dec;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign b        = req_data_byte;

   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      sets_in     = sets_ff;
      pps_in      = pps_ff;
      sps_done_in = sps_done_ff;
      lenhi_in    = lenhi_ff;
      left_in     = left_ff;
      pend_in     = pend_ff;
      pcnt_in     = pcnt_ff;
      ended       = 1'b0;
      n           = 3'd0;
      grp         = '0;
      grp.char_ok = 1'b1;
      b0          = pend_ff[15:8];
      b1          = pend_ff[7:0];
      sets_dec    = 8'd0;

      // restart: drop all progress, take this byte as header byte 0
      if (req_first) begin
         phase_in    = PhHeader;
         hdr_in      = 3'd0;
         sets_in     = 8'd0;
         pps_in      = 1'b0;
         sps_done_in = 1'b0;
         lenhi_in    = 8'd0;
         left_in     = 16'd0;
         pend_in     = 16'd0;
         pcnt_in     = 2'd0;
      end

      case (phase_in)
         PhHeader: begin
            hdr_in = hdr_in + 3'd1;
            if (hdr_in >= 3'd5) begin
               phase_in = PhSpsCount;
            end
         end
         PhSpsCount: begin
            sets_in  = {3'b000, b[4:0]};
            pps_in   = 1'b0;
            phase_in = (b[4:0] != 5'd0) ? PhLenHi : PhPpsCount;
         end
         PhPpsCount: begin
            sets_in = b;
            pps_in  = 1'b1;
            if (b != 8'd0) begin
               phase_in = PhLenHi;
            end else begin
               phase_in = PhDone;
               ended    = 1'b1;
            end
         end
         PhLenHi: begin
            lenhi_in = b;
            phase_in = PhLenLo;
         end
         PhLenLo: begin
            left_in = {lenhi_in, b};
            pend_in = 16'd0;
            pcnt_in = 2'd0;
            if (pps_in || sps_done_in) begin
               grp.chars[0] = CharComma;
               n            = 3'd1;
            end
            if (!pps_in) begin
               sps_done_in = 1'b1;
            end
            if (left_in == 16'd0) begin
               sets_dec = sets_in - 8'd1;
               sets_in  = sets_dec;
               if (sets_dec != 8'd0) begin
                  phase_in = PhLenHi;
               end else if (pps_in) begin
                  phase_in = PhDone;
                  ended    = 1'b1;
               end else begin
                  phase_in = PhPpsCount;
               end
            end else begin
               phase_in = PhData;
            end
         end
         PhData: begin
            left_in = left_in - 16'd1;
            if (pcnt_in == 2'd2) begin
               // full triple: four digits
               grp.chars[0] = b64_char(b0[7:2]);
               grp.chars[1] = b64_char({b0[1:0], b1[7:4]});
               grp.chars[2] = b64_char({b1[3:0], b[7:6]});
               grp.chars[3] = b64_char(b[5:0]);
               n            = 3'd4;
               pend_in      = 16'd0;
               pcnt_in      = 2'd0;
            end else begin
               pend_in = {pend_in[7:0], b};
               pcnt_in = pcnt_in + 2'd1;
               if (left_in == 16'd0) begin
                  if (pcnt_in == 2'd1) begin
                     grp.chars[0] = b64_char(b[7:2]);
                     grp.chars[1] = b64_char({b[1:0], 4'd0});
                     grp.chars[2] = CharPad;
                     grp.chars[3] = CharPad;
                  end else begin
                     grp.chars[0] = b64_char(pend_in[15:10]);
                     grp.chars[1] = b64_char({pend_in[9:8], b[7:4]});
                     grp.chars[2] = b64_char({b[3:0], 2'd0});
                     grp.chars[3] = CharPad;
                  end
                  n       = 3'd4;
                  pend_in = 16'd0;
                  pcnt_in = 2'd0;
               end
            end
            if (left_in == 16'd0) begin
               sets_dec = sets_in - 8'd1;
               sets_in  = sets_dec;
               if (sets_dec != 8'd0) begin
                  phase_in = PhLenHi;
               end else if (pps_in) begin
                  phase_in = PhDone;
                  ended    = 1'b1;
               end else begin
                  phase_in = PhPpsCount;
               end
            end
         end
         default: begin
         end
      endcase

      // record end with nothing to say: bare marker
      if (ended && (n == 3'd0)) begin
         grp.chars[0] = 8'd0;
         grp.char_ok  = 1'b0;
         n            = 3'd1;
      end
      grp.count = n;
      grp.last  = ended;
   end

   assign q_push = accept && (n != 3'd0);
   assign q_grp  = grp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhIdle;
         hdr_ff      <= 3'd0;
         sets_ff     <= 8'd0;
         pps_ff      <= 1'b0;
         sps_done_ff <= 1'b0;
         lenhi_ff    <= 8'd0;
         left_ff     <= 16'd0;
         pend_ff     <= 16'd0;
         pcnt_ff     <= 2'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         sets_ff     <= sets_in;
         pps_ff      <= pps_in;
         sps_done_ff <= sps_done_in;
         lenhi_ff    <= lenhi_in;
         left_ff     <= left_in;
         pend_ff     <= pend_in;
         pcnt_ff     <= pcnt_in;
      end
   end

endmodule

@@ sv/avcb64_queue.sv @@
`timescale 1ns / 1ps
module avcb64_queue #(
   parameter int Depth = avcb64_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  avcb64_pkg::grp_type push_grp,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output avcb64_pkg::grp_type pop_grp
);
   import avcb64_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(Depth);

   grp_type         mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full    = (cnt_ff == CntFull);
   assign valid   = (cnt_ff != '0);
   assign pop_grp = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_grp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ sv/avcb64_back.sv @@
`timescale 1ns / 1ps
module avcb64_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  avcb64_pkg::grp_type q_grp,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_char_valid,
   output logic                rsp_last
);
   import avcb64_pkg::*;

   grp_type    cur_ff, cur_in;
   logic [1:0] idx_ff, idx_in;
   logic       busy_ff, busy_in;
   logic       at_end;
   logic       taken;
   logic       load;

   assign at_end = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign taken  = busy_ff && rsp_pop;
   assign load   = q_valid && (!busy_ff || (taken && at_end));
   assign q_pop  = load;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (load) begin
         cur_in  = q_grp;
         idx_in  = 2'd0;
         busy_in = 1'b1;
      end else if (taken) begin
         if (at_end) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   assign rsp_empty      = !busy_ff;
   assign rsp_out_char   = cur_ff.chars[idx_ff];
   assign rsp_char_valid = cur_ff.char_ok;
   assign rsp_last       = cur_ff.last && at_end;

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

@@ sv/avcb64_checker.sv @@
`timescale 1ns / 1ps
module avcb64_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_char,
   input logic       rsp_char_valid,
   input logic       rsp_last
);

   // reset empties the result side
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   // reset frees the request side
   a_reset_room : assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // a bare end marker is always the final result of a record and carries no character
   a_bare_marker : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_char_valid) |-> (rsp_last && (rsp_out_char == 8'd0)))
      else $error("bare end marker without last or with a character");

   // a waiting result holds until taken
   a_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_out_char) && $stable(rsp_char_valid) && $stable(rsp_last)))
      else $error("waiting result changed before pop");

endmodule

bind avc_config_to_base64_param_sets_core avcb64_checker u_avcb64_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_out_char   (rsp_out_char),
   .rsp_char_valid (rsp_char_valid),
   .rsp_last       (rsp_last)
);
